FILE: rtl/core/ewh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewh_pkg: shared types and constants of the equi-width histogram estimator
// Datapath commands, controller states, status word and saturating add.
// ----------------------------------------------------------------------------
package ewh_pkg;

   localparam int unsigned DEF_NUM_BINS   = 1024;
   localparam int unsigned DEF_COUNT_BITS = 32;
   localparam logic [31:0] WORD_MAX       = 32'hFFFF_FFFF;

   // one datapath command per cycle
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_DIV_LO,
      OP_TAKE_LO,
      OP_DIV_HI,
      OP_TAKE_HI,
      OP_RD_ADD,
      OP_WR_ADD,
      OP_DROP,
      OP_HMAX,
      OP_CLAMP,
      OP_SUM_INIT,
      OP_SUM,
      OP_RD_LI,
      OP_RD_RI,
      OP_TAKE_C,
      OP_DIV_C,
      OP_TAKE_QR,
      OP_MQ,
      OP_TERM_Q,
      OP_MR,
      OP_DIV_P,
      OP_TAKE_T,
      OP_ACC,
      OP_FIN
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_LO,
      ST_WAIT_LO,
      ST_TAKE_LO,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_Q_CHK,
      ST_Q_CLAMP,
      ST_Q_CMP,
      ST_DIV_HI,
      ST_WAIT_HI,
      ST_TAKE_HI,
      ST_Q_RANGE,
      ST_SUM_INIT,
      ST_SUM,
      ST_RD_B,
      ST_TAKE_C,
      ST_DIV_C,
      ST_WAIT_C,
      ST_TAKE_QR,
      ST_MQ,
      ST_TERM_Q,
      ST_MR,
      ST_DIV_P,
      ST_WAIT_P,
      ST_TAKE_T,
      ST_ACC,
      ST_FIN
   } state_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic clr_last;
      logic div_busy;
      logic mode;
      logic empty;
      logic biu_zero;
      logic lo_gt_hi;
      logic li_oob;
      logic ri_oob;
      logic same;
      logic sum_done;
      logic out_free;
   } status_type;

   // 32-bit add saturating at all ones; b may be wider
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [63:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b[31:0]};
      if ((b[63:32] != 32'd0) || s[32]) begin
         return WORD_MAX;
      end
      return s[31:0];
   endfunction

endpackage

FILE: rtl/core/ewh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewh_div: bit-serial restoring divider
// 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ewh_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [63:0] quotient,
   output logic [31:0] remainder
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   // start load, or one restoring step while busy
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      shifted  = {rem_ff, q_ff[63]};
      diff     = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[31:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/core/ewh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewh_dp: histogram datapath
// Bin memory, divider, shared multiplier, range registers and result word.
// ----------------------------------------------------------------------------
module ewh_dp #(
   parameter int unsigned NUM_BINS   = ewh_pkg::DEF_NUM_BINS,
   parameter int unsigned COUNT_BITS = ewh_pkg::DEF_COUNT_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  ewh_pkg::op_type    op,
   output ewh_pkg::status_type status,
   input  logic               csr_valid,
   input  logic [31:0]        csr_data,
   input  logic               in_mode,
   input  logic [31:0]        in_a,
   input  logic [31:0]        in_b,
   input  logic               in_lopen,
   input  logic               in_hopen,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [39:0]        rsp_tdata
);

   localparam int unsigned IDXW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // bin store
   logic [COUNT_BITS-1:0] mem [NUM_BINS];
   logic [COUNT_BITS-1:0] rdata_ff;
   logic                  we, re;
   logic [IDXW-1:0]       wa, ra;
   logic [COUNT_BITS-1:0] wd;

   logic [31:0]   w_ff, w_eff;
   logic          mode_ff, empty_ff, drop_ff, pend_ff;
   logic [31:0]   lo_ff, hi_ff, li_ff, ri_ff, lor_ff, hir_ff;
   logic [IDXW:0] biu_ff, idx_ff, li_next;
   logic [31:0]   sum_ff, term_ff, f_ff, qlo_ff, r_ff;
   logic          qbig_ff;
   logic [COUNT_BITS-1:0] c_ff;
   logic [63:0]   prod_ff, hmax_w, rd64;
   logic [31:0]   mul_a, mul_b;
   logic          div_start, div_busy;
   logic [63:0]   div_dvd, div_q;
   logic [31:0]   div_r;
   logic          rsp_tvalid_ff;
   logic [39:0]   rsp_data_ff;
   logic          sum_more;

   assign w_eff   = (w_ff == 32'd0) ? 32'd1 : w_ff;
   assign rd64    = 64'(rdata_ff);
   assign hmax_w  = prod_ff - 64'd1;
   assign li_next = {1'b0, li_ff[IDXW-1:0]} + {{IDXW{1'b0}}, 1'b1};
   assign sum_more = idx_ff < ri_ff[IDXW:0];

   ewh_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (w_eff),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // divider and multiplier operand select, memory port control
   always_comb begin
      div_start = 1'b0;
      div_dvd   = {32'd0, lo_ff};
      mul_a     = qlo_ff;
      mul_b     = f_ff;
      we        = 1'b0;
      wa        = li_ff[IDXW-1:0];
      wd        = '0;
      re        = 1'b0;
      ra        = li_ff[IDXW-1:0];
      unique case (op)
         ewh_pkg::OP_DIV_LO: div_start = 1'b1;
         ewh_pkg::OP_DIV_HI: begin
            div_start = 1'b1;
            div_dvd   = {32'd0, hi_ff};
         end
         ewh_pkg::OP_DIV_C: begin
            div_start = 1'b1;
            div_dvd   = 64'(c_ff);
         end
         ewh_pkg::OP_DIV_P: begin
            div_start = 1'b1;
            div_dvd   = prod_ff;
         end
         ewh_pkg::OP_HMAX: begin
            mul_a = 32'(biu_ff);
            mul_b = w_eff;
         end
         ewh_pkg::OP_MR: mul_a = r_ff;
         ewh_pkg::OP_CLEAR: begin
            we = 1'b1;
            wa = idx_ff[IDXW-1:0];
         end
         ewh_pkg::OP_RD_ADD, ewh_pkg::OP_RD_LI: re = 1'b1;
         ewh_pkg::OP_RD_RI: begin
            re = 1'b1;
            ra = ri_ff[IDXW-1:0];
         end
         ewh_pkg::OP_SUM: begin
            re = sum_more;
            ra = idx_ff[IDXW-1:0];
         end
         ewh_pkg::OP_WR_ADD: begin
            we = 1'b1;
            wd = (rdata_ff == CNT_MAX) ? rdata_ff : rdata_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rdata_ff <= mem[ra];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff          <= 32'd1;
         biu_ff        <= '0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            w_ff <= csr_data;
         end
         // a new result replaces the one taken in the same cycle
         if (op == ewh_pkg::OP_FIN) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (op)
            ewh_pkg::OP_CLEAR:    idx_ff <= idx_ff + 1'b1;
            ewh_pkg::OP_WR_ADD: begin
               if (li_next > biu_ff) begin
                  biu_ff <= li_next;
               end
            end
            ewh_pkg::OP_SUM_INIT: begin
               idx_ff  <= li_next;
               pend_ff <= 1'b0;
            end
            ewh_pkg::OP_SUM: begin
               pend_ff <= sum_more;
               if (sum_more) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      unique case (op)
         ewh_pkg::OP_LOAD: begin
            mode_ff  <= in_mode;
            lo_ff    <= (in_mode && in_lopen) ? in_a + 32'd1 : in_a;
            hi_ff    <= (in_mode && in_hopen) ? in_b - 32'd1 : in_b;
            empty_ff <= (in_lopen && (in_a == ewh_pkg::WORD_MAX)) ||
                        (in_hopen && (in_b == 32'd0));
            sum_ff   <= '0;
            drop_ff  <= 1'b0;
         end
         ewh_pkg::OP_TAKE_LO: begin
            li_ff  <= div_q[31:0];
            lor_ff <= div_r;
         end
         ewh_pkg::OP_TAKE_HI: begin
            ri_ff  <= div_q[31:0];
            hir_ff <= div_r;
         end
         ewh_pkg::OP_DROP:  drop_ff <= 1'b1;
         ewh_pkg::OP_CLAMP: begin
            if (64'(hi_ff) >= prod_ff) begin
               hi_ff <= hmax_w[31:0];
            end
         end
         ewh_pkg::OP_SUM: begin
            if (pend_ff) begin
               sum_ff <= ewh_pkg::sat_add(sum_ff, rd64);
            end
         end
         // covered part of the boundary bin
         ewh_pkg::OP_RD_LI: f_ff <= (li_ff == ri_ff) ? hir_ff - lor_ff + 32'd1
                                                     : w_eff - lor_ff;
         ewh_pkg::OP_RD_RI: f_ff <= hir_ff + 32'd1;
         ewh_pkg::OP_TAKE_C: c_ff <= rdata_ff;
         ewh_pkg::OP_TAKE_QR: begin
            qlo_ff  <= div_q[31:0];
            qbig_ff <= div_q[63:32] != 32'd0;
            r_ff    <= div_r;
         end
         ewh_pkg::OP_TERM_Q: term_ff <= (qbig_ff || (prod_ff[63:32] != 32'd0)) ?
                                        ewh_pkg::WORD_MAX : prod_ff[31:0];
         ewh_pkg::OP_TAKE_T: term_ff <= ewh_pkg::sat_add(term_ff, div_q);
         ewh_pkg::OP_ACC:    sum_ff  <= ewh_pkg::sat_add(sum_ff, 64'(term_ff));
         ewh_pkg::OP_FIN:    rsp_data_ff <= {7'd0, drop_ff, sum_ff};
         default: ;
      endcase
   end

   assign status.clr_last = idx_ff == (IDXW + 1)'(NUM_BINS - 1);
   assign status.div_busy = div_busy;
   assign status.mode     = mode_ff;
   assign status.empty    = empty_ff;
   assign status.biu_zero = biu_ff == '0;
   assign status.lo_gt_hi = lo_ff > hi_ff;
   assign status.li_oob   = li_ff >= 32'(NUM_BINS);
   assign status.ri_oob   = ri_ff >= 32'(NUM_BINS);
   assign status.same     = li_ff == ri_ff;
   assign status.sum_done = !sum_more && !pend_ff;
   assign status.out_free = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/core/ewh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewh_ctrl: histogram sequencer
// Steps the datapath through clear, add and range query sequences.
// ----------------------------------------------------------------------------
module ewh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ewh_pkg::status_type status,
   output ewh_pkg::op_type     op
);

   ewh_pkg::state_type state_ff, state_in;
   logic side_ff, side_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ewh_pkg::ST_CLEAR;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
      end
   end

   // next state and command
   always_comb begin
      state_in   = state_ff;
      side_in    = side_ff;
      op         = ewh_pkg::OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ewh_pkg::ST_CLEAR: begin
            op = ewh_pkg::OP_CLEAR;
            if (status.clr_last) state_in = ewh_pkg::ST_IDLE;
         end
         ewh_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op       = ewh_pkg::OP_LOAD;
               state_in = ewh_pkg::ST_DIV_LO;
            end
         end
         ewh_pkg::ST_DIV_LO: begin
            // a query first checks for empty or inverted ranges
            if (status.mode && (state_ff == ewh_pkg::ST_DIV_LO) && !side_ff) begin
               side_in  = 1'b1;
               state_in = ewh_pkg::ST_Q_CHK;
            end else begin
               op       = ewh_pkg::OP_DIV_LO;
               side_in  = 1'b0;
               state_in = ewh_pkg::ST_WAIT_LO;
            end
         end
         ewh_pkg::ST_WAIT_LO:
            if (!status.div_busy) state_in = ewh_pkg::ST_TAKE_LO;
         ewh_pkg::ST_TAKE_LO: begin
            op       = ewh_pkg::OP_TAKE_LO;
            state_in = status.mode ? ewh_pkg::ST_DIV_HI : ewh_pkg::ST_ADD_RD;
         end
         ewh_pkg::ST_ADD_RD: begin
            if (status.li_oob) begin
               op       = ewh_pkg::OP_DROP;
               state_in = ewh_pkg::ST_FIN;
            end else begin
               op       = ewh_pkg::OP_RD_ADD;
               state_in = ewh_pkg::ST_ADD_WR;
            end
         end
         ewh_pkg::ST_ADD_WR: begin
            op       = ewh_pkg::OP_WR_ADD;
            state_in = ewh_pkg::ST_FIN;
         end
         ewh_pkg::ST_Q_CHK: begin
            if (status.empty || status.biu_zero) begin
               side_in  = 1'b0;
               state_in = ewh_pkg::ST_FIN;
            end else begin
               op       = ewh_pkg::OP_HMAX;
               state_in = ewh_pkg::ST_Q_CLAMP;
            end
         end
         ewh_pkg::ST_Q_CLAMP: begin
            op       = ewh_pkg::OP_CLAMP;
            state_in = ewh_pkg::ST_Q_CMP;
         end
         ewh_pkg::ST_Q_CMP: begin
            if (status.lo_gt_hi) begin
               side_in  = 1'b0;
               state_in = ewh_pkg::ST_FIN;
            end else begin
               state_in = ewh_pkg::ST_DIV_LO;
            end
         end
         ewh_pkg::ST_DIV_HI: begin
            op       = ewh_pkg::OP_DIV_HI;
            state_in = ewh_pkg::ST_WAIT_HI;
         end
         ewh_pkg::ST_WAIT_HI:
            if (!status.div_busy) state_in = ewh_pkg::ST_TAKE_HI;
         ewh_pkg::ST_TAKE_HI: begin
            op       = ewh_pkg::OP_TAKE_HI;
            state_in = ewh_pkg::ST_Q_RANGE;
         end
         ewh_pkg::ST_Q_RANGE:
            state_in = (status.li_oob || status.ri_oob) ? ewh_pkg::ST_FIN
                                                        : ewh_pkg::ST_SUM_INIT;
         ewh_pkg::ST_SUM_INIT: begin
            op       = ewh_pkg::OP_SUM_INIT;
            side_in  = 1'b0;
            state_in = ewh_pkg::ST_SUM;
         end
         ewh_pkg::ST_SUM: begin
            op = ewh_pkg::OP_SUM;
            if (status.sum_done) state_in = ewh_pkg::ST_RD_B;
         end
         // boundary bin: left first, then right when they differ
         ewh_pkg::ST_RD_B: begin
            op       = side_ff ? ewh_pkg::OP_RD_RI : ewh_pkg::OP_RD_LI;
            state_in = ewh_pkg::ST_TAKE_C;
         end
         ewh_pkg::ST_TAKE_C: begin
            op       = ewh_pkg::OP_TAKE_C;
            state_in = ewh_pkg::ST_DIV_C;
         end
         ewh_pkg::ST_DIV_C: begin
            op       = ewh_pkg::OP_DIV_C;
            state_in = ewh_pkg::ST_WAIT_C;
         end
         ewh_pkg::ST_WAIT_C:
            if (!status.div_busy) state_in = ewh_pkg::ST_TAKE_QR;
         ewh_pkg::ST_TAKE_QR: begin
            op       = ewh_pkg::OP_TAKE_QR;
            state_in = ewh_pkg::ST_MQ;
         end
         ewh_pkg::ST_MQ: begin
            op       = ewh_pkg::OP_MQ;
            state_in = ewh_pkg::ST_TERM_Q;
         end
         ewh_pkg::ST_TERM_Q: begin
            op       = ewh_pkg::OP_TERM_Q;
            state_in = ewh_pkg::ST_MR;
         end
         ewh_pkg::ST_MR: begin
            op       = ewh_pkg::OP_MR;
            state_in = ewh_pkg::ST_DIV_P;
         end
         ewh_pkg::ST_DIV_P: begin
            op       = ewh_pkg::OP_DIV_P;
            state_in = ewh_pkg::ST_WAIT_P;
         end
         ewh_pkg::ST_WAIT_P:
            if (!status.div_busy) state_in = ewh_pkg::ST_TAKE_T;
         ewh_pkg::ST_TAKE_T: begin
            op       = ewh_pkg::OP_TAKE_T;
            state_in = ewh_pkg::ST_ACC;
         end
         ewh_pkg::ST_ACC: begin
            op = ewh_pkg::OP_ACC;
            if (!side_ff && !status.same) begin
               side_in  = 1'b1;
               state_in = ewh_pkg::ST_RD_B;
            end else begin
               side_in  = 1'b0;
               state_in = ewh_pkg::ST_FIN;
            end
         end
         ewh_pkg::ST_FIN: begin
            if (status.out_free) begin
               op       = ewh_pkg::OP_FIN;
               side_in  = 1'b0;
               state_in = ewh_pkg::ST_IDLE;
            end
         end
         default: state_in = ewh_pkg::ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/equi_width_histogram_range_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equi_width_histogram_range_estimator: equi-width histogram with range counts
// An add word (tuser 0) counts its value in bin value/bin_width and flags a
// value beyond the bin store. A query word (tuser 1) returns the interior bin
// sum plus each boundary bin scaled by its covered fraction, saturated to 32
// bits. One word is in work at a time. After reset the bin memory is cleared
// before the first word is taken. The bit-serial divider (one pass for an add,
// up to six for a query) and the single-port walk over the interior bins set
// how long a word takes. The result sits in an output register, so a word can
// be taken while a result waits.
// ----------------------------------------------------------------------------
module equi_width_histogram_range_estimator #(
   parameter int unsigned NUM_BINS   = ewh_pkg::DEF_NUM_BINS,
   parameter int unsigned COUNT_BITS = ewh_pkg::DEF_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,   // bin_width
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // value_or_low, upper_bound, low_open, high_open
   input  logic        req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // estimated_count, entry_dropped
);

   ewh_pkg::op_type     op;
   ewh_pkg::status_type status;

   assign csr_ready = 1'b1;

   ewh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .op         (op)
   );

   ewh_dp #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .in_mode    (req_tuser),
      .in_a       (req_tdata[31:0]),
      .in_b       (req_tdata[63:32]),
      .in_lopen   (req_tdata[64]),
      .in_hopen   (req_tdata[65]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: dv/tb_equi_width_histogram_range_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_equi_width_histogram_range_estimator: bin counts and range estimates
// Drives add and query words through the stream port. The bin width is changed
// between phases, and each result is checked against a local model of the
// histogram. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_equi_width_histogram_range_estimator;

   localparam int          NBINS     = ewh_pkg::DEF_NUM_BINS;
   localparam int          CYC_LIMIT = 6_000_000;
   localparam logic        MODE_ADD  = 1'b0;
   localparam logic        MODE_QRY  = 1'b1;
   localparam logic [31:0] ALL_ONES  = ewh_pkg::WORD_MAX;

   typedef struct packed {
      logic [31:0] est;
      logic        drop;
   } estimate_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;  // value_or_low, upper_bound, low_open, high_open
   logic        req_tuser = 1'b0; // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // estimated_count, entry_dropped

   // model state
   logic [31:0] hist_bins [NBINS];
   int          hist_used;
   logic [31:0] hist_width;

   estimate_type pending_est [$];
   int          mismatches = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          burst_left = 0;
   longint      cycles = 0;

   equi_width_histogram_range_estimator dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // floor(c * f / w) without a wide product
   function automatic longint unsigned part_of_bin(longint unsigned c, longint unsigned f,
                                                   longint unsigned w);
      return (c / w) * f + ((c % w) * f) / w;
   endfunction

   function automatic longint unsigned range_estimate(longint unsigned lo, longint unsigned hi);
      longint unsigned w, hmax, li, ri, sum;
      w = (hist_width == 0) ? 64'd1 : 64'(hist_width);
      sum = 0;
      if (hist_used == 0) return 0;
      hmax = longint'(hist_used) * w - 1;
      if (hi > hmax) hi = hmax;
      if (lo > hi) return 0;
      li = lo / w;
      ri = hi / w;
      if (li >= NBINS || ri >= NBINS) return 0;
      for (longint unsigned i = li + 1; i < ri; i++) sum += 64'(hist_bins[i]);
      if (li == ri) begin
         sum += part_of_bin(64'(hist_bins[li]), hi % w - lo % w + 1, w);
      end else begin
         sum += part_of_bin(64'(hist_bins[li]), w - lo % w, w);
         sum += part_of_bin(64'(hist_bins[ri]), hi % w + 1, w);
      end
      return sum;
   endfunction

   // update the model for one accepted word and return its result
   function automatic estimate_type histogram_step(logic mode, logic [31:0] a, logic [31:0] b,
                                                   logic lopen, logic hopen);
      estimate_type    r;
      longint unsigned idx, e, lo, hi;
      logic            empty;
      r = '0;
      lo = 64'(a);
      hi = 64'(b);
      empty = 1'b0;
      if (mode == MODE_ADD) begin
         idx = longint'(a) / ((hist_width == 0) ? 1 : longint'(hist_width));
         if (idx >= NBINS) begin
            r.drop = 1'b1;
         end else begin
            if (idx + 1 > hist_used) hist_used = int'(idx) + 1;
            if (hist_bins[idx] != ALL_ONES) hist_bins[idx] += 1;
         end
      end else begin
         if (lopen) begin
            if (a == ALL_ONES) empty = 1'b1;
            else lo = lo + 1;
         end
         if (hopen) begin
            if (b == 0) empty = 1'b1;
            else hi = hi - 1;
         end
         e = empty ? 0 : range_estimate(lo, hi);
         r.est = (e > ALL_ONES) ? ALL_ONES : e[31:0];
      end
      return r;
   endfunction

   // send one word; senders work in bursts with random gaps
   task automatic send_word(logic mode, logic [31:0] a, logic [31:0] b,
                            logic lopen, logic hopen);
      req_tuser  <= mode;
      req_tdata  <= {6'd0, hopen, lopen, b, a};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_est.push_back(histogram_step(mode, a, b, lopen, hopen));
      words_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 30) : $urandom_range(0, 4);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // end any open burst, then wait for all results
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_est.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_width(logic [31:0] w);
      wait_idle();
      csr_data  <= w;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      hist_width = w;
      @(posedge clock);
   endtask

   // value landing in a chosen bin, mostly low bins, sometimes past the store
   function automatic logic [31:0] value_in_bin();
      longint unsigned idx, v;
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1100) : $urandom_range(0, 40);
      v = idx * hist_width + ($urandom % hist_width);
      return (v > ALL_ONES) ? $urandom : v[31:0];
   endfunction

   task automatic test_directed();
      write_width(32'd1);
      send_word(MODE_QRY, 32'd0, ALL_ONES, 1'b0, 1'b0);   // empty histogram
      send_word(MODE_ADD, 32'd0, ALL_ONES, 1'b1, 1'b1);
      send_word(MODE_ADD, 32'd1023, 32'd0, 1'b0, 1'b0);
      send_word(MODE_ADD, 32'd1024, 32'd0, 1'b0, 1'b0);   // dropped
      send_word(MODE_ADD, ALL_ONES, 32'd0, 1'b0, 1'b0);   // dropped
      send_word(MODE_QRY, 32'd0, ALL_ONES, 1'b0, 1'b0);   // high clamped
      send_word(MODE_QRY, ALL_ONES, ALL_ONES, 1'b1, 1'b0);
      send_word(MODE_QRY, 32'd0, 32'd0, 1'b0, 1'b1);
      send_word(MODE_QRY, 32'd5, 32'd3, 1'b0, 1'b0);      // inverted
      send_word(MODE_QRY, 32'd0, 32'd2, 1'b1, 1'b1);
      send_word(MODE_QRY, 32'd1023, 32'd1023, 1'b0, 1'b0);
      write_width(32'd7);
      send_word(MODE_ADD, 32'd20, 32'd0, 1'b0, 1'b0);
      send_word(MODE_ADD, 32'd20, 32'd0, 1'b0, 1'b0);
      send_word(MODE_QRY, 32'd15, 32'd16, 1'b0, 1'b0);    // partial, one bin
      send_word(MODE_QRY, 32'd3, 32'd30, 1'b1, 1'b1);
      write_width(ALL_ONES);
      send_word(MODE_ADD, 32'hFFFF_FFFE, 32'd0, 1'b0, 1'b0);
      send_word(MODE_ADD, ALL_ONES, 32'd0, 1'b0, 1'b0);
      send_word(MODE_QRY, 32'd0, ALL_ONES, 1'b0, 1'b0);
      send_word(MODE_QRY, 32'h8000_0000, ALL_ONES, 1'b1, 1'b0);
      send_word(MODE_QRY, ALL_ONES, ALL_ONES, 1'b0, 1'b0);
   endtask

   // mostly well-aimed adds and queries, some fully random words
   task automatic test_random(int n, logic [31:0] w);
      logic [31:0] a, b;
      write_width(w);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) begin
            send_word(1'($urandom_range(0, 1)), $urandom, $urandom,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if ($urandom_range(0, 1) == 0) begin
            send_word(MODE_ADD, value_in_bin(), $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            a = value_in_bin();
            b = ($urandom_range(0, 3) == 0) ? value_in_bin() : a + $urandom_range(0, 40) * w;
            if (b < a && $urandom_range(0, 3) != 0) b = ALL_ONES;
            send_word(MODE_QRY, a, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // receiver stall pattern: quiet stretches, then random stalls
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if ((cycles / 3000) % 3 == 0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 2) != 0);
   end

   // result checker
   always @(posedge clock) begin
      estimate_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_checked++;
         if (pending_est.size() == 0) begin
            mismatches++;
            $error("unexpected result word: est %0d drop %0b", rsp_tdata[31:0], rsp_tdata[32]);
         end else begin
            exp_r = pending_est.pop_front();
            if (rsp_tdata[31:0] !== exp_r.est) begin
               mismatches++;
               $error("estimated_count: expected %0d, got %0d", exp_r.est, rsp_tdata[31:0]);
            end
            if (rsp_tdata[32] !== exp_r.drop) begin
               mismatches++;
               $error("entry_dropped: expected %0b, got %0b", exp_r.drop, rsp_tdata[32]);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NBINS; i++) hist_bins[i] = '0;
      hist_used  = 0;
      hist_width = 32'd1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(120, 32'd1);
      test_random(120, 32'd13);
      test_random(100, $urandom_range(2, 5000));
      test_random(80, ALL_ONES);
      test_random(100, 32'd4_000_000);
      wait_idle();
      repeat (100) @(posedge clock);
      $display("covered %0d words (%0d results checked) over six bin widths incl. 1 and max",
               words_sent, words_checked);
      if (mismatches == 0 && pending_est.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
